// File: design/dem_bilinear_height_sampler_core_defines.svh
// assertion macros shared by the sampler rtl
// depends on: a clk and rst_n signal in the module that uses them
`ifndef DEM_BILINEAR_HEIGHT_SAMPLER_CORE_DEFINES_SVH
`define DEM_BILINEAR_HEIGHT_SAMPLER_CORE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define DBHS_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define DBHS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/dbhs_pkg.sv
// shared types, codes and constants of the height sampler
// depends on: nothing
package dbhs_pkg;

  localparam int DIM_W     = 13;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DAT_W = 48;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OUTSIDE  = 2'd1;
  localparam logic [1:0] ST_MISSING  = 2'd2;
  localparam logic [1:0] ST_WR_RANGE = 2'd3;

  localparam logic [2:0] PT_BYTE   = 3'd0;
  localparam logic [2:0] PT_INT16  = 3'd1;
  localparam logic [2:0] PT_UINT16 = 3'd2;
  localparam logic [2:0] PT_INT32  = 3'd3;
  localparam logic [2:0] PT_UINT32 = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_TYPE = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH      = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT     = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X   = 4'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y   = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_X_SCALE    = 4'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_SCALE    = 4'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_NODATA     = 4'd7;

  // height returned for anything but a good query
  localparam logic signed [48:0] ML_ZERO = 49'sd0;

  typedef struct packed {
    logic [2:0]         pixel_type;
    logic [8:0]         raster_width;
    logic [8:0]         raster_height;
    logic signed [47:0] origin_x;
    logic signed [47:0] origin_y;
    logic signed [31:0] x_scale;
    logic signed [31:0] y_scale;
    logic signed [32:0] nodata_value;
  } cfg_t;

  // partial products of the pixel coordinate plus write fields
  typedef struct packed {
    logic        command;
    logic        wr_bad;
    logic [7:0]  row;
    logic [7:0]  col;
    logic [31:0] wdata;
    logic [48:0] xh;
    logic [63:0] xl;
    logic        xzero;
    logic        xneg;
    logic [48:0] yh;
    logic [63:0] yl;
    logic        yzero;
    logic        yneg;
  } prod_t;

  // decoded neighbours going into the blend
  typedef struct packed {
    logic               command;
    logic [1:0]         status;
    logic signed [32:0] v0;
    logic signed [32:0] v1;
    logic signed [32:0] v2;
    logic signed [32:0] v3;
    logic [15:0]        fx;
    logic [15:0]        fy;
  } pix_t;

endpackage

// File: design/dbhs_if.sv
// request, result and configuration channels of the height sampler
// depends on: nothing
interface dbhs_req_if;
  logic               valid;
  logic               ready;
  logic               command;
  logic [7:0]         row_index;
  logic [7:0]         col_index;
  logic signed [32:0] sample_value;
  logic signed [47:0] query_x;
  logic signed [47:0] query_y;
  modport source(output valid, command, row_index, col_index, sample_value, query_x,
                 query_y, input ready);
  modport sink(input valid, command, row_index, col_index, sample_value, query_x,
               query_y, output ready);
endinterface

interface dbhs_rsp_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [48:0] height;
  modport source(output valid, status, height, input ready);
  modport sink(input valid, status, height, output ready);
endinterface

interface dbhs_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [47:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// File: design/dbhs_ram.sv
// generic simple dual port ram, one write and one registered read port
// depends on: nothing
module dbhs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: design/dbhs_cfg.sv
// configuration register file of the height sampler
// depends on: dbhs_pkg, dbhs_if
module dbhs_cfg (
  input  logic            clk,
  input  logic            rst_n,
  dbhs_cfg_if.sink        cfg_wr,
  output dbhs_pkg::cfg_t  cfg
);

  dbhs_pkg::cfg_t cfg_r, cfg_nxt;

  assign cfg_wr.ready = 1'b1;
  assign cfg = cfg_r;

  // register write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr.valid) begin
      case (cfg_wr.index)
        dbhs_pkg::CFG_PIXEL_TYPE: cfg_nxt.pixel_type    = cfg_wr.data[2:0];
        dbhs_pkg::CFG_WIDTH:      cfg_nxt.raster_width  = cfg_wr.data[8:0];
        dbhs_pkg::CFG_HEIGHT:     cfg_nxt.raster_height = cfg_wr.data[8:0];
        dbhs_pkg::CFG_ORIGIN_X:   cfg_nxt.origin_x      = cfg_wr.data[47:0];
        dbhs_pkg::CFG_ORIGIN_Y:   cfg_nxt.origin_y      = cfg_wr.data[47:0];
        dbhs_pkg::CFG_X_SCALE:    cfg_nxt.x_scale       = cfg_wr.data[31:0];
        dbhs_pkg::CFG_Y_SCALE:    cfg_nxt.y_scale       = cfg_wr.data[31:0];
        dbhs_pkg::CFG_NODATA:     cfg_nxt.nodata_value  = cfg_wr.data[32:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pixel_type    <= dbhs_pkg::PT_BYTE;
      cfg_r.raster_width  <= 9'd256;
      cfg_r.raster_height <= 9'd256;
      cfg_r.origin_x      <= '0;
      cfg_r.origin_y      <= '0;
      cfg_r.x_scale       <= 32'sd65536;
      cfg_r.y_scale       <= 32'sd65536;
      cfg_r.nodata_value  <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// File: design/dbhs_coord.sv
// front pipeline: offset from origin, magnitudes, scale partial products
// depends on: dbhs_pkg, dbhs_if
module dbhs_coord #(
  parameter int MAX_COLS = 256,
  parameter int MAX_ROWS = 256
) (
  input  logic            clk,
  input  logic            rst_n,
  input  dbhs_pkg::cfg_t  cfg,
  dbhs_req_if.sink        in_req,
  output dbhs_pkg::prod_t c_q,
  output logic            c_valid,
  input  logic            c_take
);

  localparam int DW = dbhs_pkg::DIM_W;

  logic front_adv;
  logic [DW-1:0] w_lim, h_lim;

  // stage a: offset and write checks
  logic               a_v_r, a_cmd_r, a_bad_r;
  logic [7:0]         a_row_r, a_col_r;
  logic [31:0]        a_wdata_r;
  logic signed [48:0] a_dx_r, a_dy_r;
  // stage b: magnitudes
  logic               b_v_r, b_cmd_r, b_bad_r;
  logic [7:0]         b_row_r, b_col_r;
  logic [31:0]        b_wdata_r;
  logic [48:0]        b_mdx_r, b_mdy_r;
  logic [31:0]        b_msx_r, b_msy_r;
  logic               b_xzero_r, b_xneg_r, b_yzero_r, b_yneg_r;
  // stage c: products
  logic            c_v_r;
  dbhs_pkg::prod_t c_r;

  logic [31:0] wdata_trunc;

  assign front_adv    = !c_v_r || c_take;
  assign in_req.ready = front_adv;
  assign c_valid      = c_v_r;
  assign c_q          = c_r;

  // raster size limited to the store
  always_comb begin
    w_lim = ({4'b0, cfg.raster_width} > DW'(MAX_COLS)) ? DW'(MAX_COLS)
                                                       : {4'b0, cfg.raster_width};
    h_lim = ({4'b0, cfg.raster_height} > DW'(MAX_ROWS)) ? DW'(MAX_ROWS)
                                                        : {4'b0, cfg.raster_height};
  end

  // write data truncated to the pixel type
  always_comb begin
    case (cfg.pixel_type)
      dbhs_pkg::PT_BYTE:   wdata_trunc = {24'b0, in_req.sample_value[7:0]};
      dbhs_pkg::PT_INT16,
      dbhs_pkg::PT_UINT16: wdata_trunc = {16'b0, in_req.sample_value[15:0]};
      default:             wdata_trunc = in_req.sample_value[31:0];
    endcase
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
    end else if (front_adv) begin
      a_v_r <= in_req.valid;
      b_v_r <= a_v_r;
      c_v_r <= b_v_r;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (front_adv) begin
      a_cmd_r   <= in_req.command;
      a_row_r   <= in_req.row_index;
      a_col_r   <= in_req.col_index;
      a_wdata_r <= wdata_trunc;
      a_bad_r   <= ({5'b0, in_req.row_index} >= h_lim) ||
                   ({5'b0, in_req.col_index} >= w_lim);
      a_dx_r    <= $signed({in_req.query_x[47], in_req.query_x}) -
                   $signed({cfg.origin_x[47], cfg.origin_x});
      a_dy_r    <= $signed({in_req.query_y[47], in_req.query_y}) -
                   $signed({cfg.origin_y[47], cfg.origin_y});

      b_cmd_r   <= a_cmd_r;
      b_row_r   <= a_row_r;
      b_col_r   <= a_col_r;
      b_wdata_r <= a_wdata_r;
      b_bad_r   <= a_bad_r;
      b_mdx_r   <= a_dx_r[48] ? 49'(-a_dx_r) : 49'(a_dx_r);
      b_mdy_r   <= a_dy_r[48] ? 49'(-a_dy_r) : 49'(a_dy_r);
      b_msx_r   <= cfg.x_scale[31] ? 32'(-cfg.x_scale) : 32'(cfg.x_scale);
      b_msy_r   <= cfg.y_scale[31] ? 32'(-cfg.y_scale) : 32'(cfg.y_scale);
      b_xzero_r <= (a_dx_r == '0) || (cfg.x_scale == '0);
      b_yzero_r <= (a_dy_r == '0) || (cfg.y_scale == '0);
      b_xneg_r  <= (a_dx_r[48] != cfg.x_scale[31]);
      b_yneg_r  <= (a_dy_r[48] != cfg.y_scale[31]);

      c_r.command <= b_cmd_r;
      c_r.wr_bad  <= b_bad_r;
      c_r.row     <= b_row_r;
      c_r.col     <= b_col_r;
      c_r.wdata   <= b_wdata_r;
      c_r.xh      <= b_mdx_r[48:32] * b_msx_r;
      c_r.xl      <= b_mdx_r[31:0] * b_msx_r;
      c_r.xzero   <= b_xzero_r;
      c_r.xneg    <= b_xneg_r && !b_xzero_r;
      c_r.yh      <= b_mdy_r[48:32] * b_msy_r;
      c_r.yl      <= b_mdy_r[31:0] * b_msy_r;
      c_r.yzero   <= b_yzero_r;
      c_r.yneg    <= b_yneg_r && !b_yzero_r;
    end
  end

endmodule

// File: design/dbhs_blend.sv
// back pipeline: row blends, column blend, result register
// depends on: dbhs_pkg, dbhs_if
module dbhs_blend (
  input  logic           clk,
  input  logic           rst_n,
  input  dbhs_pkg::pix_t p,
  input  logic           p_valid,
  output logic           p_ready,
  dbhs_rsp_if.source     out_rsp
);

  logic tail_adv;

  logic               g_v_r, g_cmd_r;
  logic [1:0]         g_st_r;
  logic signed [32:0] g_v0_r, g_v2_r;
  logic signed [33:0] g_d1_r, g_d2_r;
  logic [15:0]        g_fx_r, g_fy_r;

  logic               h_v_r, h_cmd_r;
  logic [1:0]         h_st_r;
  logic signed [50:0] h_top_r, h_bot_r;
  logic [15:0]        h_fy_r;

  logic               i_v_r, i_cmd_r;
  logic [1:0]         i_st_r;
  logic signed [50:0] i_top_r;
  logic signed [51:0] i_dt_r;
  logic [15:0]        i_fy_r;

  logic               out_v_r;
  logic [1:0]         out_st_r;
  logic signed [48:0] out_h_r;

  logic signed [50:0] m_top, m_bot, top_sum, bot_sum;
  logic signed [69:0] m_col, total;

  assign tail_adv       = !out_v_r || out_rsp.ready;
  assign p_ready        = tail_adv;
  assign out_rsp.valid  = out_v_r;
  assign out_rsp.status = out_st_r;
  assign out_rsp.height = out_h_r;

  // horizontal blend of each row
  always_comb begin
    m_top   = g_d1_r * $signed({1'b0, g_fx_r});
    m_bot   = g_d2_r * $signed({1'b0, g_fx_r});
    top_sum = $signed({{2{g_v0_r[32]}}, g_v0_r, 16'b0}) + m_top;
    bot_sum = $signed({{2{g_v2_r[32]}}, g_v2_r, 16'b0}) + m_bot;
  end

  // vertical blend, q.32 total
  always_comb begin
    m_col = i_dt_r * $signed({1'b0, i_fy_r});
    total = $signed({{3{i_top_r[50]}}, i_top_r, 16'b0}) + m_col;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_v_r   <= 1'b0;
      h_v_r   <= 1'b0;
      i_v_r   <= 1'b0;
      out_v_r <= 1'b0;
    end else if (tail_adv) begin
      g_v_r   <= p_valid;
      h_v_r   <= g_v_r;
      i_v_r   <= h_v_r;
      out_v_r <= i_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (tail_adv) begin
      g_cmd_r <= p.command;
      g_st_r  <= p.status;
      g_v0_r  <= p.v0;
      g_v2_r  <= p.v2;
      g_d1_r  <= $signed({p.v1[32], p.v1}) - $signed({p.v0[32], p.v0});
      g_d2_r  <= $signed({p.v3[32], p.v3}) - $signed({p.v2[32], p.v2});
      g_fx_r  <= p.fx;
      g_fy_r  <= p.fy;

      h_cmd_r <= g_cmd_r;
      h_st_r  <= g_st_r;
      h_top_r <= top_sum;
      h_bot_r <= bot_sum;
      h_fy_r  <= g_fy_r;

      i_cmd_r <= h_cmd_r;
      i_st_r  <= h_st_r;
      i_top_r <= h_top_r;
      i_dt_r  <= $signed({h_bot_r[50], h_bot_r}) - $signed({h_top_r[50], h_top_r});
      i_fy_r  <= h_fy_r;

      out_st_r <= i_st_r;
      out_h_r  <= (i_cmd_r == dbhs_pkg::CMD_QUERY && i_st_r == dbhs_pkg::ST_OK)
                  ? total[64:16] : dbhs_pkg::ML_ZERO;
    end
  end

endmodule

// File: design/dem_bilinear_height_sampler_core.sv
// dem bilinear height sampler, top level: fetch sequencer over the sample ram
// throughput: one write per cycle when results are not stalled; a query holds the
// fetch stage for its four neighbour reads through the single read port of the
// sample ram
// reset: registers take their defaults and the pipeline empties; the sample
// ram is not cleared, an unwritten sample reads as whatever the ram holds
module dem_bilinear_height_sampler_core #(
  parameter int MAX_COLS = 256,
  parameter int MAX_ROWS = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  dbhs_cfg_if.sink   cfg_wr,
  dbhs_req_if.sink   in_req,
  dbhs_rsp_if.source out_rsp
);

`include "dem_bilinear_height_sampler_core_defines.svh"

  localparam int DW    = dbhs_pkg::DIM_W;
  localparam int CW    = $clog2(MAX_COLS);
  localparam int RW    = $clog2(MAX_ROWS);
  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = $clog2(DEPTH);

  dbhs_pkg::cfg_t  cfg;
  dbhs_pkg::prod_t c_q;
  dbhs_pkg::pix_t  pix;
  logic            c_valid, blend_ready;
  logic            e_load;

  dbhs_cfg u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_wr (cfg_wr),
    .cfg    (cfg)
  );

  dbhs_coord #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_coord (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .in_req  (in_req),
    .c_q     (c_q),
    .c_valid (c_valid),
    .c_take  (e_load)
  );

  // raster size limited to the store
  logic [DW-1:0] w_lim, h_lim;
  always_comb begin
    w_lim = ({4'b0, cfg.raster_width} > DW'(MAX_COLS)) ? DW'(MAX_COLS)
                                                       : {4'b0, cfg.raster_width};
    h_lim = ({4'b0, cfg.raster_height} > DW'(MAX_ROWS)) ? DW'(MAX_ROWS)
                                                        : {4'b0, cfg.raster_height};
  end

  // pixel coordinate, range and edge checks
  logic [63:0] qx, qy, px, py, lim_x, lim_y;
  logic        x_out, y_out, edge_hit;
  logic [1:0]  st_in;
  logic [CW-1:0] c0_in;
  logic [RW-1:0] r0_in;
  always_comb begin
    qx    = {c_q.xh[47:0], 16'b0} + {16'b0, c_q.xl[63:16]};
    qy    = {c_q.yh[47:0], 16'b0} + {16'b0, c_q.yl[63:16]};
    lim_x = {35'b0, DW'(w_lim - DW'(1)), 16'b0};
    lim_y = {35'b0, DW'(h_lim - DW'(1)), 16'b0};
    x_out = c_q.xneg || (!c_q.xzero && (qx > lim_x));
    y_out = c_q.yneg || (!c_q.yzero && (qy > lim_y));
    px    = c_q.xzero ? 64'd0 : qx;
    py    = c_q.yzero ? 64'd0 : qy;
    c0_in = px[16 +: CW];
    r0_in = py[16 +: RW];
    edge_hit = ((DW'(c0_in) + DW'(1)) >= w_lim) || ((DW'(r0_in) + DW'(1)) >= h_lim);
    if (c_q.command == dbhs_pkg::CMD_WRITE) begin
      st_in = c_q.wr_bad ? dbhs_pkg::ST_WR_RANGE : dbhs_pkg::ST_OK;
    end else if (w_lim == '0 || h_lim == '0 || x_out || y_out) begin
      st_in = dbhs_pkg::ST_OUTSIDE;
    end else if (edge_hit) begin
      st_in = dbhs_pkg::ST_MISSING;
    end else begin
      st_in = dbhs_pkg::ST_OK;
    end
  end

  // fetch stage: one item, up to four neighbour reads
  logic          e_v_r, e_cmd_r;
  logic [1:0]    e_st_r, e_cnt_r;
  logic [CW-1:0] e_c0_r;
  logic [RW-1:0] e_r0_r;
  logic [15:0]   e_fx_r, e_fy_r;
  logic [7:0]    e_row_r, e_col_r;
  logic [31:0]   e_wdata_r;
  logic [31:0]   e_s0_r, e_s1_r, e_s2_r;

  logic          e_done, ok_q, f_can, rd_en, ram_we;
  logic          rd_v_r;
  logic [1:0]    rd_slot_r;
  logic [31:0]   e_off;
  logic [AW-1:0] raddr, waddr;
  logic [31:0]   ram_rdata;

  // blend entry stage
  logic        f_v_r, f_need3_r, f_cmd_r, f_go;
  logic [1:0]  f_st_r;
  logic [15:0] f_fx_r, f_fy_r;
  logic [31:0] f_s0_r, f_s1_r, f_s2_r, f_s3_r;

  assign ok_q   = e_v_r && e_cmd_r == dbhs_pkg::CMD_QUERY && e_st_r == dbhs_pkg::ST_OK;
  assign f_go   = f_v_r && !f_need3_r && blend_ready;
  assign f_can  = !f_v_r || f_go;
  assign e_done = e_v_r && f_can && (!ok_q || e_cnt_r == 2'd3);
  assign e_load = c_valid && (!e_v_r || e_done);
  assign rd_en  = ok_q && (e_cnt_r != 2'd3 || f_can);
  assign ram_we = e_done && e_cmd_r == dbhs_pkg::CMD_WRITE && e_st_r == dbhs_pkg::ST_OK;

  // neighbour offset per read
  always_comb begin
    case (e_cnt_r)
      2'd0:    e_off = 32'd0;
      2'd1:    e_off = 32'd1;
      2'd2:    e_off = 32'(MAX_COLS);
      default: e_off = 32'(MAX_COLS) + 32'd1;
    endcase
    raddr = AW'(32'(e_r0_r) * MAX_COLS + 32'(e_c0_r) + e_off);
    waddr = AW'(32'(e_row_r) * MAX_COLS + 32'(e_col_r));
  end

  dbhs_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (e_wdata_r),
    .re    (rd_en),
    .raddr (raddr),
    .rdata (ram_rdata)
  );

  // fetch control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_v_r   <= 1'b0;
      e_cnt_r <= 2'd0;
      rd_v_r  <= 1'b0;
    end else begin
      rd_v_r <= rd_en;
      if (e_load) begin
        e_v_r   <= 1'b1;
        e_cnt_r <= 2'd0;
      end else begin
        if (e_done) begin
          e_v_r <= 1'b0;
        end
        if (rd_en && e_cnt_r != 2'd3) begin
          e_cnt_r <= e_cnt_r + 2'd1;
        end
      end
    end
  end

  // fetch payload and returning samples
  always_ff @(posedge clk) begin
    rd_slot_r <= e_cnt_r;
    if (e_load) begin
      e_cmd_r   <= c_q.command;
      e_st_r    <= st_in;
      e_c0_r    <= c0_in;
      e_r0_r    <= r0_in;
      e_fx_r    <= px[15:0];
      e_fy_r    <= py[15:0];
      e_row_r   <= c_q.row;
      e_col_r   <= c_q.col;
      e_wdata_r <= c_q.wdata;
    end
    if (rd_v_r) begin
      case (rd_slot_r)
        2'd0:    e_s0_r <= ram_rdata;
        2'd1:    e_s1_r <= ram_rdata;
        2'd2:    e_s2_r <= ram_rdata;
        default: ;
      endcase
    end
  end

  // blend entry control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_v_r     <= 1'b0;
      f_need3_r <= 1'b0;
    end else begin
      if (e_done) begin
        f_v_r     <= 1'b1;
        f_need3_r <= ok_q;
      end else begin
        if (f_go) begin
          f_v_r <= 1'b0;
        end
        if (rd_v_r && rd_slot_r == 2'd3) begin
          f_need3_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (e_done) begin
      f_cmd_r <= e_cmd_r;
      f_st_r  <= e_st_r;
      f_fx_r  <= e_fx_r;
      f_fy_r  <= e_fy_r;
      f_s0_r  <= e_s0_r;
      f_s1_r  <= e_s1_r;
      f_s2_r  <= (rd_v_r && rd_slot_r == 2'd2) ? ram_rdata : e_s2_r;
    end
    if (rd_v_r && rd_slot_r == 2'd3) begin
      f_s3_r <= ram_rdata;
    end
  end

  // sample extension by pixel type
  function automatic logic signed [32:0] ext_sample(input logic [31:0] raw,
                                                    input logic [2:0] pt);
    logic signed [32:0] v;
    case (pt)
      dbhs_pkg::PT_BYTE:   v = {25'b0, raw[7:0]};
      dbhs_pkg::PT_INT16:  v = {{17{raw[15]}}, raw[15:0]};
      dbhs_pkg::PT_UINT16: v = {17'b0, raw[15:0]};
      dbhs_pkg::PT_INT32:  v = {raw[31], raw};
      default:             v = {1'b0, raw};
    endcase
    return v;
  endfunction

  // decode neighbours and test for nodata
  logic nodata_hit, type_bad;
  always_comb begin
    pix.command = f_cmd_r;
    pix.fx      = f_fx_r;
    pix.fy      = f_fy_r;
    pix.v0      = ext_sample(f_s0_r, cfg.pixel_type);
    pix.v1      = ext_sample(f_s1_r, cfg.pixel_type);
    pix.v2      = ext_sample(f_s2_r, cfg.pixel_type);
    pix.v3      = ext_sample(f_s3_r, cfg.pixel_type);
    type_bad    = cfg.pixel_type > dbhs_pkg::PT_UINT32;
    nodata_hit  = (pix.v0 == cfg.nodata_value) || (pix.v1 == cfg.nodata_value) ||
                  (pix.v2 == cfg.nodata_value) || (pix.v3 == cfg.nodata_value);
    if (f_cmd_r == dbhs_pkg::CMD_QUERY && f_st_r == dbhs_pkg::ST_OK &&
        (type_bad || nodata_hit)) begin
      pix.status = dbhs_pkg::ST_MISSING;
    end else begin
      pix.status = f_st_r;
    end
  end

  dbhs_blend u_blend (
    .clk     (clk),
    .rst_n   (rst_n),
    .p       (pix),
    .p_valid (f_v_r && !f_need3_r),
    .p_ready (blend_ready),
    .out_rsp (out_rsp)
  );

  // a blend entry waiting on its last sample has that read in flight
  `DBHS_ASSERT_IMPLIES(a_need3_inflight, f_need3_r, rd_v_r && rd_slot_r == 2'd3, "no last read")
  // the read counter only runs for a good query
  `DBHS_ASSERT_IMPLIES(a_cnt_query, e_v_r && e_cnt_r != 2'd0, ok_q, "counter off a query")
  // a query handed on waits for its last sample
  `DBHS_ASSERT_NEXT(a_handoff_wait, e_done && ok_q, f_v_r && f_need3_r, "handoff lost last read")

endmodule

// File: tb/dbhs_tb_pkg.sv
// coordinate mapping shared by the sampler testbench stimulus and checker
// depends on: dbhs_pkg
package dbhs_tb_pkg;
  timeunit 1ns;
  timeprecision 1ps;
  import dbhs_pkg::*;

  // rows or columns actually usable, clipped to the ram size
  function automatic int unsigned dim_in_use(logic [8:0] v);
    return (v > 9'd256) ? 256 : int'(v);
  endfunction

  // map one axis to Q.16 pixel units, false when the point falls outside
  function automatic logic axis_to_pixel(input logic signed [47:0] q,
                                         input logic signed [47:0] o,
                                         input logic signed [31:0] s,
                                         input int unsigned n,
                                         output logic [31:0] p);
    logic signed [48:0] d;
    logic [48:0] md;
    logic [31:0] ms;
    logic [95:0] prod;
    p = '0;
    d = q - o;
    if (n == 0) return 1'b0;
    if (d == 0 || s == 0) return 1'b1;
    if (d[48] != s[31]) return 1'b0;
    md = d[48] ? -d : d;
    ms = s[31] ? -s : s;
    prod = ({47'd0, md} * {64'd0, ms}) >> 16;
    if (prod > (96'(n - 1) << 16)) return 1'b0;
    p = prod[31:0];
    return 1'b1;
  endfunction

  // locate a query point, giving the top-left pixel and both fractions
  function automatic logic locate_point(input cfg_t c,
                                        input logic signed [47:0] qx,
                                        input logic signed [47:0] qy,
                                        output logic [31:0] px,
                                        output logic [31:0] py);
    logic okx, oky;
    okx = axis_to_pixel(qx, c.origin_x, c.x_scale, dim_in_use(c.raster_width), px);
    oky = axis_to_pixel(qy, c.origin_y, c.y_scale, dim_in_use(c.raster_height), py);
    return okx && oky;
  endfunction
endpackage

// File: tb/dbhs_height_checker.sv
// watches the request, result and register channels and predicts each height
// depends on: dbhs_pkg, dbhs_tb_pkg, dbhs_if
module dbhs_height_checker (
  input  logic        clk,
  input  logic        rst_n,
  dbhs_req_if         req,
  dbhs_rsp_if         rsp,
  dbhs_cfg_if         cfg,
  output int          fail_count,
  output int          pending,
  output int          results_seen,
  output int          heights_ok
);
  timeunit 1ns;
  timeprecision 1ps;
  import dbhs_pkg::*;
  import dbhs_tb_pkg::*;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [48:0] height;
  } height_rsp_t;

  cfg_t        regs;
  logic [31:0] sample_ram [0:65535];
  height_rsp_t expected_heights[$];

  task automatic report_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
    $display("mismatch %s: expected %0h got %0h at %0t", what, want, got, $realtime);
    fail_count++;
  endtask

  // raw ram word to a sample value by pixel type
  function automatic logic signed [32:0] decode_sample(logic [31:0] raw);
    case (regs.pixel_type)
      PT_BYTE:   return {25'd0, raw[7:0]};
      PT_INT16:  return {{17{raw[15]}}, raw[15:0]};
      PT_UINT16: return {17'd0, raw[15:0]};
      PT_INT32:  return {raw[31], raw};
      default:   return {1'b0, raw};
    endcase
  endfunction

  function automatic height_rsp_t predict_query(logic signed [47:0] qx,
                                                logic signed [47:0] qy);
    height_rsp_t r;
    logic [31:0] px, py;
    int unsigned w, h, c0, r0;
    logic signed [32:0] v [4];
    logic signed [95:0] wt [4];
    logic signed [95:0] acc;
    logic [16:0] fx, fy;
    r = '{status: ST_OK, height: ML_ZERO};
    w = dim_in_use(regs.raster_width);
    h = dim_in_use(regs.raster_height);
    if (!locate_point(regs, qx, qy, px, py)) begin
      r.status = ST_OUTSIDE;
      return r;
    end
    c0 = px[31:16];
    r0 = py[31:16];
    if (c0 + 1 >= w || r0 + 1 >= h || regs.pixel_type > PT_UINT32) begin
      r.status = ST_MISSING;
      return r;
    end
    v[0] = decode_sample(sample_ram[r0 * 256 + c0]);
    v[1] = decode_sample(sample_ram[r0 * 256 + c0 + 1]);
    v[2] = decode_sample(sample_ram[(r0 + 1) * 256 + c0]);
    v[3] = decode_sample(sample_ram[(r0 + 1) * 256 + c0 + 1]);
    for (int i = 0; i < 4; i++) begin
      if (v[i] == regs.nodata_value) begin
        r.status = ST_MISSING;
        return r;
      end
    end
    fx = {1'b0, px[15:0]};
    fy = {1'b0, py[15:0]};
    wt[0] = (17'h10000 - fx) * (17'h10000 - fy);
    wt[1] = fx * (17'h10000 - fy);
    wt[2] = (17'h10000 - fx) * fy;
    wt[3] = fx * fy;
    acc = '0;
    for (int i = 0; i < 4; i++) acc = acc + wt[i] * 96'(v[i]);
    acc = acc >>> 16;
    r.height = acc[48:0];
    return r;
  endfunction

  // register writes, requests and results, all sampled at the rising edge
  always @(posedge clk) begin
    height_rsp_t e;
    int unsigned w, h;
    if (!rst_n) begin
      regs = '{pixel_type: PT_BYTE, raster_width: 9'd256, raster_height: 9'd256,
               origin_x: '0, origin_y: '0, x_scale: 32'sd65536, y_scale: 32'sd65536,
               nodata_value: '0};
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          CFG_PIXEL_TYPE: regs.pixel_type = cfg.data[2:0];
          CFG_WIDTH:      regs.raster_width = cfg.data[8:0];
          CFG_HEIGHT:     regs.raster_height = cfg.data[8:0];
          CFG_ORIGIN_X:   regs.origin_x = cfg.data;
          CFG_ORIGIN_Y:   regs.origin_y = cfg.data;
          CFG_X_SCALE:    regs.x_scale = cfg.data[31:0];
          CFG_Y_SCALE:    regs.y_scale = cfg.data[31:0];
          CFG_NODATA:     regs.nodata_value = cfg.data[32:0];
          default: ;
        endcase
      end
      if (req.valid && req.ready) begin
        if (req.command == CMD_WRITE) begin
          e = '{status: ST_OK, height: ML_ZERO};
          w = dim_in_use(regs.raster_width);
          h = dim_in_use(regs.raster_height);
          if (req.row_index >= h || req.col_index >= w) begin
            e.status = ST_WR_RANGE;
          end else begin
            case (regs.pixel_type)
              PT_BYTE:            sample_ram[{req.row_index, req.col_index}] =
                                    {24'd0, req.sample_value[7:0]};
              PT_INT16, PT_UINT16: sample_ram[{req.row_index, req.col_index}] =
                                    {16'd0, req.sample_value[15:0]};
              default:            sample_ram[{req.row_index, req.col_index}] =
                                    req.sample_value[31:0];
            endcase
          end
        end else begin
          e = predict_query(req.query_x, req.query_y);
        end
        expected_heights.push_back(e);
      end
      if (rsp.valid && rsp.ready) begin
        results_seen++;
        if (expected_heights.size() == 0) begin
          report_mismatch("unexpected result", 64'd0, {rsp.status, rsp.height});
        end else begin
          e = expected_heights.pop_front();
          if (rsp.status != e.status) report_mismatch("status", e.status, rsp.status);
          if (rsp.height != e.height) report_mismatch("height", e.height, rsp.height);
          if (e.status == ST_OK && e.height != ML_ZERO) heights_ok++;
        end
      end
      pending = expected_heights.size();
    end
  end

  initial begin
    fail_count = 0;
    pending = 0;
    results_seen = 0;
    heights_ok = 0;
  end
endmodule

// File: tb/tb_dem_bilinear_height_sampler_core.sv
// testbench top of the height sampler: clock, reset, stimulus and verdict
// depends on: dbhs_pkg, dbhs_tb_pkg, dbhs_if, dbhs_height_checker, the core
module tb_dem_bilinear_height_sampler_core;
  timeunit 1ns;
  timeprecision 1ps;
  import dbhs_pkg::*;
  import dbhs_tb_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   fail_count, pending, results_seen, heights_ok;
  int   sent_writes = 0;
  int   sent_queries = 0;
  cfg_t shadow;
  bit   written [0:65535];
  bit   no_stall = 1'b0;
  int   out_hold = 0;

  dbhs_req_if in_ch ();
  dbhs_rsp_if out_ch ();
  dbhs_cfg_if cfg_ch ();

  dem_bilinear_height_sampler_core i_dut (
    .clk(clk), .rst_n(rst_n), .cfg_wr(cfg_ch), .in_req(in_ch), .out_rsp(out_ch)
  );

  dbhs_height_checker i_checker (
    .clk(clk), .rst_n(rst_n), .req(in_ch), .rsp(out_ch), .cfg(cfg_ch),
    .fail_count(fail_count), .pending(pending), .results_seen(results_seen),
    .heights_ok(heights_ok)
  );

  always #4 clk = ~clk;

  initial begin
    #24_000_000;
    $display("timeout waiting for the sampler");
    $display("RESULT: ERROR");
    $finish;
  end

  // idle length: mostly short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_stall || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // result side stalls
  always @(negedge clk) begin
    if (out_hold > 0) begin
      out_ch.ready <= 1'b0;
      out_hold <= out_hold - 1;
    end else begin
      out_ch.ready <= 1'b1;
      out_hold <= pick_gap();
    end
  end

  function automatic logic [32:0] rand33();
    return {1'($urandom_range(0, 1)), 32'($urandom)};
  endfunction

  function automatic logic [47:0] rand48();
    logic [63:0] t;
    t = {$urandom, $urandom};
    return t[47:0];
  endfunction

  function automatic logic [32:0] rand_sample();
    case ($urandom_range(0, 9))
      0: return shadow.nodata_value;
      1: return 33'd0;
      2: return 33'h1_FFFF_FFFF;
      3: return 33'h0_FFFF_FFFF;
      4: return 33'h1_8000_0000;
      5: return 33'($urandom_range(0, 255));
      default: return rand33();
    endcase
  endfunction

  // one request; valid stays high into the next one when there is no gap
  task automatic push_request(input logic cmd, input logic [7:0] row,
                              input logic [7:0] col, input logic [32:0] sample,
                              input logic [47:0] qx, input logic [47:0] qy);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk) in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.command <= cmd;
    in_ch.row_index <= row;
    in_ch.col_index <= col;
    in_ch.sample_value <= sample;
    in_ch.query_x <= qx;
    in_ch.query_y <= qy;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic put_write(input logic [7:0] row, input logic [7:0] col,
                           input logic [32:0] sample);
    if (row < dim_in_use(shadow.raster_height) && col < dim_in_use(shadow.raster_width))
      written[{row, col}] = 1'b1;
    sent_writes++;
    push_request(CMD_WRITE, row, col, sample, rand48(), rand48());
  endtask

  // a query first fills any of its four neighbours that were never written
  task automatic put_query(input logic [47:0] qx, input logic [47:0] qy);
    logic [31:0] px, py;
    int unsigned c0, r0;
    if (locate_point(shadow, qx, qy, px, py)) begin
      c0 = px[31:16];
      r0 = py[31:16];
      if (c0 + 1 < dim_in_use(shadow.raster_width) &&
          r0 + 1 < dim_in_use(shadow.raster_height)) begin
        for (int i = 0; i < 4; i++) begin
          if (!written[(r0 + i / 2) * 256 + c0 + i % 2])
            put_write(8'(r0 + i / 2), 8'(c0 + i % 2), rand_sample());
        end
      end
    end
    sent_queries++;
    push_request(CMD_QUERY, 8'($urandom), 8'($urandom), rand33(), qx, qy);
  endtask

  // map coordinate that lands near a wanted Q.16 pixel position
  function automatic logic [47:0] aim(input logic signed [47:0] o,
                                      input logic signed [31:0] s,
                                      input longint unsigned p);
    logic signed [95:0] num, den, d;
    if (s == 0) return ($urandom_range(0, 1) != 0) ? o : rand48();
    num = 96'(p) << 16;
    den = s;
    d = num / den;
    return o + d[47:0];
  endfunction

  // drain everything outstanding, then leave room for the pipeline
  task automatic wait_idle();
    @(negedge clk) in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [3:0] idx, input logic [47:0] value);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk) cfg_ch.valid <= 1'b0;
    case (idx)
      CFG_PIXEL_TYPE: shadow.pixel_type = value[2:0];
      CFG_WIDTH:      shadow.raster_width = value[8:0];
      CFG_HEIGHT:     shadow.raster_height = value[8:0];
      CFG_ORIGIN_X:   shadow.origin_x = value;
      CFG_ORIGIN_Y:   shadow.origin_y = value;
      CFG_X_SCALE:    shadow.x_scale = value[31:0];
      CFG_Y_SCALE:    shadow.y_scale = value[31:0];
      default:        shadow.nodata_value = value[32:0];
    endcase
  endtask

  task automatic apply_cfg(input cfg_t c);
    wait_idle();
    cfg_write(CFG_PIXEL_TYPE, 48'(c.pixel_type));
    cfg_write(CFG_WIDTH, 48'(c.raster_width));
    cfg_write(CFG_HEIGHT, 48'(c.raster_height));
    cfg_write(CFG_ORIGIN_X, c.origin_x);
    cfg_write(CFG_ORIGIN_Y, c.origin_y);
    cfg_write(CFG_X_SCALE, {16'd0, c.x_scale});
    cfg_write(CFG_Y_SCALE, {16'd0, c.y_scale});
    cfg_write(CFG_NODATA, {15'd0, c.nodata_value});
  endtask

  function automatic logic [31:0] pick_scale();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'hFFFF_0000;
      3: return 32'h0000_8000;
      4: return 32'h0002_0000;
      5: return 32'd1;
      6: return 32'd0;
      7: return $urandom;
      default: return 32'h0001_0000;
    endcase
  endfunction

  function automatic logic [8:0] pick_dim();
    case ($urandom_range(0, 9))
      0: return 9'd0;
      1: return 9'd1;
      2: return 9'd256;
      3: return 9'd511;
      4: return 9'd300;
      5: return 9'd2;
      default: return 9'($urandom_range(3, 24));
    endcase
  endfunction

  function automatic cfg_t random_cfg();
    cfg_t c;
    c.pixel_type = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(5, 7))
                                              : 3'($urandom_range(0, 4));
    c.raster_width = pick_dim();
    c.raster_height = pick_dim();
    case ($urandom_range(0, 3))
      0: begin c.origin_x = 48'h7FFF_FFFF_FFFF; c.origin_y = 48'h8000_0000_0000; end
      1: begin c.origin_x = rand48(); c.origin_y = rand48(); end
      default: begin
        c.origin_x = 48'($signed($urandom_range(0, 2000000)) - 1000000);
        c.origin_y = 48'($signed($urandom_range(0, 2000000)) - 1000000);
      end
    endcase
    c.x_scale = pick_scale();
    c.y_scale = pick_scale();
    case ($urandom_range(0, 6))
      0: c.nodata_value = 33'h1_8000_0000;
      1: c.nodata_value = 33'h0_FFFF_FFFF;
      2: c.nodata_value = 33'h1_FFFF_FFFF;
      3: c.nodata_value = rand33();
      default: c.nodata_value = 33'($urandom_range(0, 300));
    endcase
    return c;
  endfunction

  // mostly writes in or just past the raster and aimed queries, the rest pure noise
  task automatic random_phase(input int n);
    int unsigned w, h, r;
    longint unsigned px, py;
    w = dim_in_use(shadow.raster_width);
    h = dim_in_use(shadow.raster_height);
    no_stall = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 30) begin
        put_write(8'($urandom_range(0, (h > 0 ? h : 1) + 1)),
                  8'($urandom_range(0, (w > 0 ? w : 1) + 1)), rand_sample());
      end else if (r < 80) begin
        px = longint'($urandom_range(0, w)) * 65536 + $urandom_range(0, 65535);
        py = longint'($urandom_range(0, h)) * 65536 + $urandom_range(0, 65535);
        if ($urandom_range(0, 5) == 0) px = longint'(w > 0 ? w - 1 : 0) * 65536;
        if ($urandom_range(0, 5) == 0) py = longint'($urandom_range(0, h)) * 65536;
        put_query(aim(shadow.origin_x, shadow.x_scale, px),
                  aim(shadow.origin_y, shadow.y_scale, py));
      end else if (r < 90) begin
        put_write(8'($urandom), 8'($urandom), rand33());
      end else begin
        put_query(rand48(), rand48());
      end
    end
    no_stall = 1'b0;
  endtask

  initial begin
    cfg_t c;
    in_ch.valid = 1'b0;
    in_ch.command = CMD_WRITE;
    in_ch.row_index = '0;
    in_ch.col_index = '0;
    in_ch.sample_value = '0;
    in_ch.query_x = '0;
    in_ch.query_y = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_PIXEL_TYPE;
    cfg_ch.data = '0;
    shadow = '{pixel_type: PT_BYTE, raster_width: 9'd256, raster_height: 9'd256,
               origin_x: '0, origin_y: '0, x_scale: 32'sd65536, y_scale: 32'sd65536,
               nodata_value: '0};
    repeat (3) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // directed: reset settings, byte samples, one pixel per map unit
    put_write(8'd0, 8'd0, 33'h10);
    put_write(8'd0, 8'd1, 33'h0_FFFF_FFFF);
    put_write(8'd1, 8'd0, 33'h1FF);
    put_write(8'd1, 8'd1, 33'h1);
    put_write(8'd255, 8'd255, 33'h1_FFFF_FFFF);
    put_query(48'd0, 48'd0);
    put_query(48'h8000, 48'h8000);
    put_query(48'hFFFF, 48'h1);
    put_query(48'hFFFF_FFFF_FFFF, 48'd0);
    put_query(48'd0, 48'hFFFF_FFFF_FFFF);
    put_query(48'h00FF_0000, 48'h0);
    put_query(48'h0, 48'h00FE_8000);
    put_query(48'h00FF_0001, 48'h0);
    put_query(48'h7FFF_FFFF_FFFF, 48'h7FFF_FFFF_FFFF);
    put_query(48'h8000_0000_0000, 48'h0);
    put_write(8'd2, 8'd2, 33'h100);
    put_query(48'h0002_0000, 48'h0002_0000);
    put_query(48'h0001_4000, 48'h0001_C000);

    // directed: narrow raster for out-of-range writes
    c = shadow;
    c.raster_width = 9'd4;
    c.raster_height = 9'd3;
    apply_cfg(c);
    put_write(8'd0, 8'd4, 33'h5);
    put_write(8'd3, 8'd0, 33'h5);
    put_write(8'd2, 8'd3, 33'h5);
    put_query(48'h0003_0000, 48'h0001_0000);

    // fixed extreme settings first, then random ones
    c = '{pixel_type: PT_INT32, raster_width: 9'd256, raster_height: 9'd256,
          origin_x: 48'h8000_0000_0000, origin_y: 48'h7FFF_FFFF_FFFF,
          x_scale: 32'h8000_0000, y_scale: 32'h7FFF_FFFF,
          nodata_value: 33'h1_8000_0000};
    apply_cfg(c);
    random_phase(60);
    c = '{pixel_type: PT_UINT32, raster_width: 9'd0, raster_height: 9'd511,
          origin_x: '0, origin_y: '0, x_scale: 32'h0001_0000, y_scale: 32'h0,
          nodata_value: 33'h0_FFFF_FFFF};
    apply_cfg(c);
    random_phase(30);
    c = '{pixel_type: PT_INT16, raster_width: 9'd1, raster_height: 9'd1,
          origin_x: 48'd1000, origin_y: 48'hFFFF_FFFF_0000, x_scale: 32'hFFFF_0000,
          y_scale: 32'h0000_8000, nodata_value: 33'h1_FFFF_FFFF};
    apply_cfg(c);
    random_phase(30);
    for (int p = 0; p < 10; p++) begin
      apply_cfg(random_cfg());
      random_phase(65);
    end

    // drain and verdict
    @(negedge clk) in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (30) @(negedge clk);
    $display("sent %0d writes and %0d queries over 15 register settings",
             sent_writes, sent_queries);
    $display("checked %0d results, %0d of them nonzero interpolated heights",
             results_seen, heights_ok);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
